FILE: hdl/tdr_pkg.sv
// Shared types and constants for the triangle depth rasterizer.
// No dependencies; compiled first.
package tdr_pkg;

  localparam int unsigned COORD_W = 16;  // vertex coordinate
  localparam int unsigned DEPTH_W = 24;  // Q0.24 depth
  localparam int unsigned RC_W    = 8;   // read coordinate
  localparam int unsigned DIFF_W  = 17;  // vertex difference
  localparam int unsigned OFS_W   = 18;  // box corner minus vertex
  localparam int unsigned EDGE_W  = 36;  // edge function
  localparam int unsigned AREA_W  = 33;  // positive area, unsigned
  localparam int unsigned SUM_W   = 57;  // weighted depth sum
  localparam int unsigned HALF_W  = 17;  // split of an edge value for the multiplier
  localparam int unsigned MA_W    = 18;
  localparam int unsigned MB_W    = 25;
  localparam int unsigned PROD_W  = 43;
  localparam int unsigned ACC_W   = 60;

  localparam logic [DEPTH_W-1:0] FAR_DEPTH = '1;

  typedef logic [1:0] action_t;
  localparam action_t ACT_CLEAR = 2'd0;
  localparam action_t ACT_DRAW  = 2'd1;
  localparam action_t ACT_READ  = 2'd2;

  typedef struct packed {
    action_t            action;
    logic signed [15:0] v0_x;
    logic signed [15:0] v0_y;
    logic        [23:0] v0_depth;
    logic signed [15:0] v1_x;
    logic signed [15:0] v1_y;
    logic        [23:0] v1_depth;
    logic signed [15:0] v2_x;
    logic signed [15:0] v2_y;
    logic        [23:0] v2_depth;
    logic        [7:0]  read_x;
    logic        [7:0]  read_y;
  } tdr_in_t;

  typedef struct packed {
    logic [23:0] read_depth;
    logic        triangle_skipped;
  } tdr_out_t;

endpackage

FILE: hdl/tdr_if.sv
// Valid/ready channel interfaces for command and response items.
// Depends on tdr_pkg.
interface tdr_in_if import tdr_pkg::*; ();
  logic    valid;
  logic    ready;
  tdr_in_t data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

interface tdr_out_if import tdr_pkg::*; ();
  logic     valid;
  logic     ready;
  tdr_out_t data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

FILE: hdl/tdr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tdr_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

FILE: hdl/tdr_div.sv
// Restoring divider, one quotient bit per cycle; quotient known to fit DEPTH_W.
// Depends on tdr_pkg.
module tdr_div import tdr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [SUM_W-1:0]   dividend,
  input  logic [AREA_W-1:0]  divisor,
  output logic               done,
  output logic [DEPTH_W-1:0] quotient
);
  logic                busy;
  logic [4:0]          cnt;
  logic [AREA_W-1:0]   rem;
  logic [AREA_W-1:0]   dvs;
  logic [DEPTH_W-1:0]  num;
  logic [AREA_W:0]     trial;
  logic [AREA_W:0]     diff;
  logic                ge;

  assign trial    = {rem, num[DEPTH_W-1]};
  assign diff     = trial - {1'b0, dvs};
  assign ge       = trial >= {1'b0, dvs};
  assign quotient = num;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        // upper part is below the divisor since the quotient fits
        rem  <= dividend[SUM_W-1:DEPTH_W];
        num  <= dividend[DEPTH_W-1:0];
        dvs  <= divisor;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        rem <= ge ? diff[AREA_W-1:0] : trial[AREA_W-1:0];
        num <= {num[DEPTH_W-2:0], ge};
        cnt <= cnt + 5'd1;
        if (cnt == 5'(DEPTH_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

FILE: hdl/triangle_depth_rasterizer_unit.sv
// Top level: depth-only triangle rasterizer with a sequenced shared multiplier.
// Depends on tdr_pkg, tdr_if, tdr_ram, tdr_div.
//
//  channel | dir | payload   | handshake
//  --------+-----+-----------+-------------------------------
//  cmd     | in  | tdr_in_t  | valid/ready, taken when both high
//  rsp     | out | tdr_out_t | valid/ready, taken when both high
//
// Clear writes FAR_DEPTH to all MAP_SIZE' * MAP_SIZE' store entries (MAP_SIZE' =
// MAP_SIZE rounded up to a power of two), one store write per cycle. Read does one
// registered store read. Draw computes the area and edge values, then walks the
// clamped box; each covered pixel makes six passes through the one 18x25 multiplier
// and 24 divider steps. Reset runs the same clear sweep with cmd.ready low.
// One item is in work at a time; a finished result sits in the rsp register and
// the next item is accepted while it waits.
module triangle_depth_rasterizer_unit import tdr_pkg::*; #(
  parameter int MAP_SIZE = 256
) (
  input  logic       clk,
  input  logic       rst,
  tdr_in_if.sink     cmd,
  tdr_out_if.source  rsp
);
  localparam int CW    = $clog2(MAP_SIZE);
  localparam int AW    = 2 * CW;
  localparam int DEPTH = 1 << AW;
  localparam logic [CW-1:0]             MAX_C = CW'(MAP_SIZE - 1);
  localparam logic signed [COORD_W-1:0] MAX_S = COORD_W'(MAP_SIZE - 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CLR  = 4'd1;
  localparam logic [3:0] S_MUL  = 4'd2;
  localparam logic [3:0] S_BOX  = 4'd3;
  localparam logic [3:0] S_PIX  = 4'd4;
  localparam logic [3:0] S_DIV  = 4'd5;
  localparam logic [3:0] S_CMP  = 4'd6;
  localparam logic [3:0] S_STEP = 4'd7;
  localparam logic [3:0] S_RD   = 4'd8;
  localparam logic [3:0] S_RDW  = 4'd9;
  localparam logic [3:0] S_OUT  = 4'd10;

  // multiplier op codes
  localparam logic [3:0] OP_AREA0 = 4'd0;
  localparam logic [3:0] OP_AREA1 = 4'd1;
  localparam logic [3:0] OP_E0A   = 4'd2;
  localparam logic [3:0] OP_E0B   = 4'd3;
  localparam logic [3:0] OP_E1A   = 4'd4;
  localparam logic [3:0] OP_E1B   = 4'd5;
  localparam logic [3:0] OP_E2A   = 4'd6;
  localparam logic [3:0] OP_E2B   = 4'd7;
  localparam logic [3:0] OP_S0LO  = 4'd8;
  localparam logic [3:0] OP_S0HI  = 4'd9;
  localparam logic [3:0] OP_S1LO  = 4'd10;
  localparam logic [3:0] OP_S1HI  = 4'd11;
  localparam logic [3:0] OP_S2LO  = 4'd12;
  localparam logic [3:0] OP_S2HI  = 4'd13;

  logic [3:0] state;

  // latched item
  logic signed [COORD_W-1:0] vx [3];
  logic signed [COORD_W-1:0] vy [3];
  logic [DEPTH_W-1:0]        vz [3];
  logic [RC_W-1:0]           rx;
  logic [RC_W-1:0]           ry;

  // result
  logic [DEPTH_W-1:0] res_depth;
  logic               res_skip;

  // clear sweep
  logic [AW-1:0] clr_cnt;
  logic          clr_report;

  // draw state
  logic [3:0]                op;
  logic                      phase;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W-1:0]   acc_next;
  logic signed [ACC_W-1:0]   term;
  logic signed [AREA_W:0]    area;
  logic signed [EDGE_W-1:0]  e_row [3];
  logic signed [EDGE_W-1:0]  e_cur [3];
  logic [CW-1:0] lox, hix, loy, hiy, px, py;

  // edge coefficients: e_i = a_i*(py - y_j) - b_i*(px - x_j)
  logic signed [DIFF_W-1:0] a_c [3];
  logic signed [DIFF_W-1:0] b_c [3];
  logic signed [OFS_W-1:0]  ox [3];
  logic signed [OFS_W-1:0]  oy [3];
  logic signed [MA_W-1:0]   ma;
  logic signed [MB_W-1:0]   mb;
  logic                     op_sub, op_shift, op_first;

  logic signed [COORD_W-1:0] minx, maxx, miny, maxy;
  logic box_empty, covered, rd_ok;

  // memory and divider
  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [DEPTH_W-1:0]  ram_wdata, ram_rdata;
  logic                div_start, div_done;
  logic [DEPTH_W-1:0]  quotient;
  logic [15:0]         rx16, ry16;

  always_comb begin
    a_c[0] = DIFF_W'(vx[1]) - DIFF_W'(vx[2]);
    b_c[0] = DIFF_W'(vy[1]) - DIFF_W'(vy[2]);
    a_c[1] = DIFF_W'(vx[2]) - DIFF_W'(vx[0]);
    b_c[1] = DIFF_W'(vy[2]) - DIFF_W'(vy[0]);
    a_c[2] = DIFF_W'(vx[0]) - DIFF_W'(vx[1]);
    b_c[2] = DIFF_W'(vy[0]) - DIFF_W'(vy[1]);
    for (int i = 0; i < 3; i++) begin
      ox[i] = $signed({{(OFS_W-CW){1'b0}}, lox}) - OFS_W'(vx[i]);
      oy[i] = $signed({{(OFS_W-CW){1'b0}}, loy}) - OFS_W'(vy[i]);
    end
  end

  // operand select for the shared multiplier
  always_comb begin
    ma = '0;
    mb = '0;
    case (op)
      OP_AREA0: begin ma = MA_W'(b_c[0]); mb = MB_W'(a_c[1]); end
      OP_AREA1: begin ma = MA_W'(a_c[0]); mb = MB_W'(b_c[1]); end
      OP_E0A:   begin ma = MA_W'(a_c[0]); mb = MB_W'(oy[2]); end
      OP_E0B:   begin ma = MA_W'(b_c[0]); mb = MB_W'(ox[2]); end
      OP_E1A:   begin ma = MA_W'(a_c[1]); mb = MB_W'(oy[0]); end
      OP_E1B:   begin ma = MA_W'(b_c[1]); mb = MB_W'(ox[0]); end
      OP_E2A:   begin ma = MA_W'(a_c[2]); mb = MB_W'(oy[1]); end
      OP_E2B:   begin ma = MA_W'(b_c[2]); mb = MB_W'(ox[1]); end
      OP_S0LO:  begin ma = {1'b0, e_cur[0][HALF_W-1:0]}; mb = {1'b0, vz[0]}; end
      OP_S0HI:  begin ma = {2'b0, e_cur[0][AREA_W-1:HALF_W]}; mb = {1'b0, vz[0]}; end
      OP_S1LO:  begin ma = {1'b0, e_cur[1][HALF_W-1:0]}; mb = {1'b0, vz[1]}; end
      OP_S1HI:  begin ma = {2'b0, e_cur[1][AREA_W-1:HALF_W]}; mb = {1'b0, vz[1]}; end
      OP_S2LO:  begin ma = {1'b0, e_cur[2][HALF_W-1:0]}; mb = {1'b0, vz[2]}; end
      OP_S2HI:  begin ma = {2'b0, e_cur[2][AREA_W-1:HALF_W]}; mb = {1'b0, vz[2]}; end
      default:  begin ma = '0; mb = '0; end
    endcase
  end

  // accumulate rules: odd setup ops subtract, odd sum ops are the high halves,
  // each group starts from zero
  always_comb begin
    op_sub   = (op == OP_AREA1) || (op == OP_E0B) || (op == OP_E1B) || (op == OP_E2B);
    op_shift = (op == OP_S0HI) || (op == OP_S1HI) || (op == OP_S2HI);
    op_first = (op == OP_AREA0) || (op == OP_E0A) || (op == OP_E1A) ||
               (op == OP_E2A) || (op == OP_S0LO);
    term     = ACC_W'(prod);
    if (op_shift) begin
      term = term <<< HALF_W;
    end
    acc_next = op_sub ? ((op_first ? '0 : acc) - term) : ((op_first ? '0 : acc) + term);
  end

  // bounding box
  always_comb begin
    minx = vx[0];
    maxx = vx[0];
    miny = vy[0];
    maxy = vy[0];
    for (int i = 1; i < 3; i++) begin
      if (vx[i] < minx) minx = vx[i];
      if (vx[i] > maxx) maxx = vx[i];
      if (vy[i] < miny) miny = vy[i];
      if (vy[i] > maxy) maxy = vy[i];
    end
    box_empty = (minx > MAX_S) || (maxx < 0) || (miny > MAX_S) || (maxy < 0);
  end

  assign covered = !e_cur[0][EDGE_W-1] && !e_cur[1][EDGE_W-1] && !e_cur[2][EDGE_W-1];
  assign rd_ok   = (int'(cmd.data.read_x) < MAP_SIZE) && (int'(cmd.data.read_y) < MAP_SIZE);
  assign rx16    = 16'(rx);
  assign ry16    = 16'(ry);

  // store ports
  assign ram_we    = (state == S_CLR) || ((state == S_CMP) && (quotient < ram_rdata));
  assign ram_waddr = (state == S_CLR) ? clr_cnt : {py, px};
  assign ram_wdata = (state == S_CLR) ? FAR_DEPTH : quotient;
  assign ram_re    = (state == S_RD) || ((state == S_PIX) && covered);
  assign ram_raddr = (state == S_RD) ? {ry16[CW-1:0], rx16[CW-1:0]} : {py, px};

  assign div_start = (state == S_MUL) && phase && (op == OP_S2HI);

  assign cmd.ready = (state == S_IDLE);

  tdr_ram #(
    .WIDTH (DEPTH_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tdr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (acc_next[SUM_W-1:0]),
    .divisor  (area[AREA_W-1:0]),
    .done     (div_done),
    .quotient (quotient)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLR;
      clr_cnt    <= '0;
      clr_report <= 1'b0;
      rsp.valid  <= 1'b0;
      op         <= '0;
      phase      <= 1'b0;
    end else begin
      // in S_OUT the output register is reloaded below instead
      if (rsp.valid && rsp.ready && (state != S_OUT)) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            vx[0] <= cmd.data.v0_x;  vy[0] <= cmd.data.v0_y;  vz[0] <= cmd.data.v0_depth;
            vx[1] <= cmd.data.v1_x;  vy[1] <= cmd.data.v1_y;  vz[1] <= cmd.data.v1_depth;
            vx[2] <= cmd.data.v2_x;  vy[2] <= cmd.data.v2_y;  vz[2] <= cmd.data.v2_depth;
            rx        <= cmd.data.read_x;
            ry        <= cmd.data.read_y;
            res_depth <= '0;
            res_skip  <= 1'b0;
            unique case (cmd.data.action)
              ACT_CLEAR: begin
                clr_cnt    <= '0;
                clr_report <= 1'b1;
                state      <= S_CLR;
              end
              ACT_DRAW: begin
                op    <= OP_AREA0;
                phase <= 1'b0;
                state <= S_MUL;
              end
              ACT_READ: state <= rd_ok ? S_RD : S_OUT;
              default:  state <= S_OUT;
            endcase
          end
        end
        S_CLR: begin
          clr_cnt <= clr_cnt + AW'(1);
          if (clr_cnt == '1) begin
            state <= clr_report ? S_OUT : S_IDLE;
          end
        end
        S_MUL: begin
          if (!phase) begin
            prod  <= ma * mb;
            phase <= 1'b1;
          end else begin
            acc   <= acc_next;
            phase <= 1'b0;
            op    <= op + 4'd1;
            unique case (op)
              OP_AREA1: begin
                area  <= (AREA_W + 1)'(acc_next);
                state <= S_BOX;
              end
              OP_E0B: begin
                e_row[0] <= EDGE_W'(acc_next);
                e_cur[0] <= EDGE_W'(acc_next);
              end
              OP_E1B: begin
                e_row[1] <= EDGE_W'(acc_next);
                e_cur[1] <= EDGE_W'(acc_next);
              end
              OP_E2B: begin
                e_row[2] <= EDGE_W'(acc_next);
                e_cur[2] <= EDGE_W'(acc_next);
                state    <= S_PIX;
              end
              OP_S2HI: state <= S_DIV;
              default: ;
            endcase
          end
        end
        S_BOX: begin
          if (area <= 0) begin
            res_skip <= 1'b1;
            state    <= S_OUT;
          end else if (box_empty) begin
            state <= S_OUT;
          end else begin
            lox   <= (minx < 0) ? '0 : CW'(minx);
            loy   <= (miny < 0) ? '0 : CW'(miny);
            hix   <= (maxx > MAX_S) ? MAX_C : CW'(maxx);
            hiy   <= (maxy > MAX_S) ? MAX_C : CW'(maxy);
            px    <= (minx < 0) ? '0 : CW'(minx);
            py    <= (miny < 0) ? '0 : CW'(miny);
            op    <= OP_E0A;
            phase <= 1'b0;
            state <= S_MUL;
          end
        end
        S_PIX: begin
          if (covered) begin
            op    <= OP_S0LO;
            phase <= 1'b0;
            state <= S_MUL;
          end else begin
            state <= S_STEP;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_CMP;
          end
        end
        S_CMP: state <= S_STEP;
        S_STEP: begin
          if (px == hix) begin
            if (py == hiy) begin
              state <= S_OUT;
            end else begin
              py <= py + CW'(1);
              px <= lox;
              for (int i = 0; i < 3; i++) begin
                e_row[i] <= e_row[i] + EDGE_W'(a_c[i]);
                e_cur[i] <= e_row[i] + EDGE_W'(a_c[i]);
              end
              state <= S_PIX;
            end
          end else begin
            px <= px + CW'(1);
            for (int i = 0; i < 3; i++) begin
              e_cur[i] <= e_cur[i] - EDGE_W'(b_c[i]);
            end
            state <= S_PIX;
          end
        end
        S_RD:  state <= S_RDW;
        S_RDW: begin
          res_depth <= ram_rdata;
          state     <= S_OUT;
        end
        S_OUT: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid                 <= 1'b1;
            rsp.data.read_depth       <= res_depth;
            rsp.data.triangle_skipped <= res_skip;
            state                     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // store is never written while waiting for an item
  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !ram_we)
    else $error("store written while idle");

  // divider finishes only while the sequencer waits for it
  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV))
    else $error("divider done outside wait state");

  // a new result appears only from the output state
  a_rsp_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> ($past(state) == S_OUT))
    else $error("response raised outside output state");

endmodule

FILE: tb/tdr_depth_checker.sv
// Checker for the triangle depth rasterizer: watches cmd and rsp, predicts each
// response from its own copy of the depth store and compares it field by field.
// Depends on tdr_pkg and tdr_if.
module tdr_depth_checker import tdr_pkg::*; #(
  parameter int MAP_SIZE = 256
) (
  input  logic clk,
  input  logic rst,
  tdr_in_if    cmd,
  tdr_out_if   rsp,
  output int   fail_count,
  output int   pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [DEPTH_W-1:0] depth_map [MAP_SIZE*MAP_SIZE];
  tdr_out_t           expected_rsp [$];

  function automatic void fill_far();
    foreach (depth_map[i]) depth_map[i] = FAR_DEPTH;
  endfunction

  // Returns 1 for a skipped (non-positive area) triangle.
  function automatic logic rasterize(tdr_in_t it);
    longint x0, y0, x1, y1, x2, y2, area, lox, hix, loy, hiy, e0, e1, e2;
    longint unsigned wsum, d;
    x0 = it.v0_x; y0 = it.v0_y; x1 = it.v1_x; y1 = it.v1_y; x2 = it.v2_x; y2 = it.v2_y;
    area = (x1 - x2) * (y0 - y2) - (y1 - y2) * (x0 - x2);
    if (area <= 0) return 1'b1;
    lox = x0 < x1 ? x0 : x1; lox = lox < x2 ? lox : x2;
    loy = y0 < y1 ? y0 : y1; loy = loy < y2 ? loy : y2;
    hix = x0 > x1 ? x0 : x1; hix = hix > x2 ? hix : x2;
    hiy = y0 > y1 ? y0 : y1; hiy = hiy > y2 ? hiy : y2;
    if (lox < 0) lox = 0;
    if (loy < 0) loy = 0;
    if (hix > MAP_SIZE - 1) hix = MAP_SIZE - 1;
    if (hiy > MAP_SIZE - 1) hiy = MAP_SIZE - 1;
    for (longint py = loy; py <= hiy; py++) begin
      for (longint px = lox; px <= hix; px++) begin
        e0 = (x1 - x2) * (py - y2) - (y1 - y2) * (px - x2);
        e1 = (x2 - x0) * (py - y0) - (y2 - y0) * (px - x0);
        e2 = (x0 - x1) * (py - y1) - (y0 - y1) * (px - x1);
        if (e0 < 0 || e1 < 0 || e2 < 0) continue;
        wsum = longint'(e0) * it.v0_depth + longint'(e1) * it.v1_depth
             + longint'(e2) * it.v2_depth;
        d = wsum / longint'(area);
        if (d < depth_map[py * MAP_SIZE + px])
          depth_map[py * MAP_SIZE + px] = DEPTH_W'(d);
      end
    end
    return 1'b0;
  endfunction

  function automatic tdr_out_t predict_rsp(tdr_in_t it);
    tdr_out_t r;
    r = '0;
    case (it.action)
      ACT_CLEAR: fill_far();
      ACT_DRAW:  r.triangle_skipped = rasterize(it);
      ACT_READ:
        if (it.read_x < MAP_SIZE && it.read_y < MAP_SIZE)
          r.read_depth = depth_map[int'(it.read_y) * MAP_SIZE + int'(it.read_x)];
      default: ;
    endcase
    return r;
  endfunction

  initial begin
    fail_count    = 0;
    pending_count = 0;
    fill_far();
  end

  always @(posedge clk) begin
    tdr_out_t want;
    if (!rst) begin
      if (cmd.valid && cmd.ready) expected_rsp.push_back(predict_rsp(cmd.data));
      if (rsp.valid && rsp.ready) begin
        if (expected_rsp.size() == 0) begin
          $display("%0t: unexpected response depth=%h skipped=%b", $time,
                   rsp.data.read_depth, rsp.data.triangle_skipped);
          fail_count++;
        end else begin
          want = expected_rsp.pop_front();
          if (want.read_depth !== rsp.data.read_depth) begin
            $display("%0t: read_depth expected %h actual %h", $time,
                     want.read_depth, rsp.data.read_depth);
            fail_count++;
          end
          if (want.triangle_skipped !== rsp.data.triangle_skipped) begin
            $display("%0t: triangle_skipped expected %b actual %b", $time,
                     want.triangle_skipped, rsp.data.triangle_skipped);
            fail_count++;
          end
        end
      end
    end
    pending_count = expected_rsp.size();
  end
endmodule

FILE: tb/testbench.sv
// Top of the rasterizer testbench: clock, reset, command stimulus, response
// back-pressure, watchdog and verdict. Depends on tdr_pkg, tdr_if, tdr_depth_checker.
module testbench;
  import tdr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAP_SIZE   = 256;
  localparam int N_RANDOM   = 700;
  localparam int CALM_TAIL  = 100;      // last items: no idling on either side
  localparam int IN_W       = $bits(tdr_in_t);
  // A clamped box of 1024 pixels is the slowest draw sent; a clear or the reset
  // sweep writes every store entry. Limit is several times the longer of the two.
  localparam int IDLE_LIMIT = 400_000;

  logic clk, rst;
  int   fail_count, pending_count;
  bit   calm;
  int   n_draw, n_read, n_clear, n_other, idle_cycles;
  int   last_x, last_y;

  tdr_in_if  cmd ();
  tdr_out_if rsp ();

  triangle_depth_rasterizer_unit #(.MAP_SIZE(MAP_SIZE)) u_dut (
    .clk(clk), .rst(rst), .cmd(cmd), .rsp(rsp)
  );

  tdr_depth_checker #(.MAP_SIZE(MAP_SIZE)) u_checker (
    .clk(clk), .rst(rst), .cmd(cmd), .rsp(rsp),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: cycles with no handshake on either channel.
  always @(posedge clk) begin
    if ((cmd.valid && cmd.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", idle_cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Response back-pressure: ready drops for random bursts, outside the calm tail.
  initial begin
    rsp.ready <= 1'b0;
    @(posedge clk);
    forever begin
      rsp.ready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      if (!calm && $urandom_range(0, 2) == 0) begin
        rsp.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
    end
  end

  function automatic longint tri_area(tdr_in_t it);
    return (longint'(it.v1_x) - it.v2_x) * (longint'(it.v0_y) - it.v2_y)
         - (longint'(it.v1_y) - it.v2_y) * (longint'(it.v0_x) - it.v2_x);
  endfunction

  // Swap v1/v2 so the winding gives area > 0 (ccw) or area < 0 (cw).
  function automatic tdr_in_t set_winding(tdr_in_t it, bit ccw);
    tdr_in_t s;
    longint a;
    a = tri_area(it);
    s = it;
    if ((ccw && a < 0) || (!ccw && a > 0)) begin
      s.v1_x = it.v2_x; s.v1_y = it.v2_y; s.v1_depth = it.v2_depth;
      s.v2_x = it.v1_x; s.v2_y = it.v1_y; s.v2_depth = it.v1_depth;
    end
    return s;
  endfunction

  function automatic tdr_in_t make_tri(int ax, int ay, int bx, int by, int cx, int cy,
                                       int za, int zb, int zc);
    tdr_in_t it;
    it = tdr_in_t'(IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                          $urandom}));
    it.action = ACT_DRAW;
    it.v0_x = 16'(ax); it.v0_y = 16'(ay); it.v0_depth = 24'(za);
    it.v1_x = 16'(bx); it.v1_y = 16'(by); it.v1_depth = 24'(zb);
    it.v2_x = 16'(cx); it.v2_y = 16'(cy); it.v2_depth = 24'(zc);
    return it;
  endfunction

  function automatic tdr_in_t make_read(int rx, int ry);
    tdr_in_t it;
    it = tdr_in_t'(IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                          $urandom}));
    it.action = ACT_READ;
    it.read_x = 8'(rx);
    it.read_y = 8'(ry);
    return it;
  endfunction

  // Small triangle near the map, mostly ccw; box at most 16x16 pixels.
  function automatic tdr_in_t rand_small_tri();
    int bx, by;
    bx = $urandom_range(0, MAP_SIZE + 8) - 8;
    by = $urandom_range(0, MAP_SIZE + 8) - 8;
    return set_winding(make_tri(bx + $urandom_range(0, 15), by + $urandom_range(0, 15),
                                bx + $urandom_range(0, 15), by + $urandom_range(0, 15),
                                bx + $urandom_range(0, 15), by + $urandom_range(0, 15),
                                $urandom, $urandom, $urandom),
                       $urandom_range(0, 9) != 0);
  endfunction

  task automatic send(tdr_in_t it, bit gaps);
    case (it.action)
      ACT_CLEAR: n_clear++;
      ACT_DRAW:  n_draw++;
      ACT_READ:  n_read++;
      default:   n_other++;
    endcase
    if (it.action == ACT_DRAW && it.v0_x >= 0 && it.v0_x < MAP_SIZE) begin
      last_x = it.v0_x;
      last_y = it.v0_y;
    end
    cmd.data  <= it;
    cmd.valid <= 1'b1;
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
    if (gaps && $urandom_range(0, 3) == 0) begin
      cmd.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  initial begin
    tdr_in_t it;
    int      pick;
    rst       <= 1'b1;
    cmd.valid <= 1'b0;
    cmd.data  <= '0;
    calm      = 1'b0;
    n_draw = 0; n_read = 0; n_clear = 0; n_other = 0;
    last_x = 0; last_y = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty store, near/far depths, winding, clamping, unused code.
    send(make_read(0, 0), 1'b0);
    send(make_read(255, 255), 1'b0);
    send(set_winding(make_tri(0, 0, 0, 10, 10, 0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF), 1),
         1'b1);
    send(make_read(1, 1), 1'b0);
    send(set_winding(make_tri(0, 0, 0, 10, 10, 0, 0, 24'hFFFFFF, 24'h800000), 1), 1'b1);
    send(make_read(0, 0), 1'b0);
    send(make_read(3, 4), 1'b0);
    send(set_winding(make_tri(0, 0, 0, 10, 10, 0, 0, 0, 0), 1), 1'b1);
    send(make_read(2, 2), 1'b0);
    // degenerate (collinear) and clockwise: skipped
    send(make_tri(5, 5, 10, 10, 20, 20, 0, 0, 0), 1'b1);
    send(set_winding(make_tri(40, 40, 40, 50, 50, 40, 0, 0, 0), 0), 1'b0);
    send(make_read(41, 41), 1'b0);
    // ccw but entirely off the map
    send(set_winding(make_tri(-30, -30, -20, -30, -30, -20, 0, 0, 0), 1), 1'b0);
    // extreme coordinates, clamped to thin boxes at both map edges
    send(set_winding(make_tri(-32768, -32768, 3, -32768, 2, 32767, 100, 200, 300), 1), 1'b1);
    send(set_winding(make_tri(252, -32768, 32767, 0, 253, 32767, 5, 24'hFFFFFE, 77), 1),
         1'b1);
    send(make_read(2, 128), 1'b0);
    send(make_read(254, 10), 1'b0);
    // extreme coordinates, clockwise: skipped before any walk
    send(set_winding(make_tri(-32768, 32767, 32767, -32768, 32767, 32767, 0, 0, 0), 0),
         1'b0);
    it = tdr_in_t'('1);
    send(it, 1'b0);  // unused action code, all fields ones
    send(make_read(128, 128), 1'b0);
    it = '0;
    it.action = ACT_CLEAR;
    send(it, 1'b1);
    send(make_read(2, 2), 1'b0);
    send(make_read(254, 10), 1'b0);

    // Random: mostly small drawable triangles and reads near recent draws.
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM - CALM_TAIL) calm = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 45) it = rand_small_tri();
      else if (pick < 85)
        it = make_read((last_x + $urandom_range(0, 15)) % MAP_SIZE,
                       (last_y + $urandom_range(0, 15)) % MAP_SIZE);
      else if (pick < 93) begin
        // noise draw with full-range fields, forced clockwise
        it = tdr_in_t'(IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                              $urandom}));
        it.action = ACT_DRAW;
        it = set_winding(it, 0);
      end else if (pick < 96) begin
        it = make_read(0, 0);
        it.read_x = 8'($urandom);
        it.read_y = 8'($urandom);
      end else if (pick < 99) begin
        it = tdr_in_t'(IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                              $urandom}));
        it.action = 2'd3;
      end else begin
        it = tdr_in_t'(IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                              $urandom}));
        it.action = ACT_CLEAR;
      end
      send(it, !calm);
    end
    cmd.valid <= 1'b0;

    // let the checker log the last accepted item before waiting on its count
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("covered %0d draws, %0d reads, %0d clears, %0d unused-code items",
             n_draw, n_read, n_clear, n_other);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
